>>> src/icr_pkg.sv
package icr_pkg;

    localparam int MAX_ROWS = 32;
    localparam longint unsigned MAX_COLUMNS = 64'd65536;

    localparam int FIELD_W     = 64;
    localparam int ROW_COUNT_W = 6;
    localparam int MIN_RUN_W   = 17;
    localparam int POS_W       = 16;
    localparam int LEN_W       = POS_W + 1;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 17;

    localparam logic [7:0] GAP_BYTE = 8'h2D;

    // Last usable column index: the smaller of MAX_COLUMNS-1 and the index range
    localparam longint unsigned POS_MAX = (longint'(1) << POS_W) - 1;
    localparam logic [POS_W-1:0] POS_LIMIT =
        ((MAX_COLUMNS - 1) > POS_MAX) ? POS_W'(POS_MAX) : POS_W'(MAX_COLUMNS - 1);

    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_COUNT = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_RUN   = CFG_INDEX_W'(1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic identical;
        logic last;
    } t_token;

    typedef struct packed {
        logic   valid;
        t_token token;
    } t_queue_head;

endpackage

>>> src/icr_front.sv
module icr_front
    import icr_pkg::*;
(
    input  logic [FIELD_W-1:0]     i_rows_0_to_7,
    input  logic [FIELD_W-1:0]     i_rows_8_to_15,
    input  logic [FIELD_W-1:0]     i_rows_16_to_23,
    input  logic [FIELD_W-1:0]     i_rows_24_to_31,
    input  logic                   i_last_column,
    input  logic [ROW_COUNT_W-1:0] i_row_count,
    output t_token                 o_token
);

    logic [4*FIELD_W-1:0]   all_rows;
    logic [ROW_COUNT_W-1:0] eff_rows;
    logic [7:0]             first;
    logic                   match;

    assign all_rows = {i_rows_24_to_31, i_rows_16_to_23, i_rows_8_to_15, i_rows_0_to_7};
    assign first    = all_rows[7:0];

    // Clamp the row count into 1..MAX_ROWS
    always_comb begin
        if (i_row_count == '0) begin
            eff_rows = ROW_COUNT_W'(1);
        end else if (i_row_count > ROW_COUNT_W'(MAX_ROWS)) begin
            eff_rows = ROW_COUNT_W'(MAX_ROWS);
        end else begin
            eff_rows = i_row_count;
        end
    end

    // Compare every used row against row 0 in parallel; a gap in row 0 never matches
    always_comb begin
        match = (first != GAP_BYTE);
        for (int r = 1; r < MAX_ROWS; r++) begin
            if ((ROW_COUNT_W'(r) < eff_rows) && (all_rows[r*8 +: 8] != first)) begin
                match = 1'b0;
            end
        end
    end

    assign o_token.identical = match;
    assign o_token.last      = i_last_column;

endmodule

>>> src/icr_queue.sv
module icr_queue
    import icr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_token      i_token,
    output logic        o_full,
    input  logic        i_pop,
    output t_queue_head o_head
);

    t_token                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CW-1:0]   r_count,  n_count;

    function automatic logic [QUEUE_AW-1:0] ptr_inc(input logic [QUEUE_AW-1:0] p);
        ptr_inc = (p == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : p + QUEUE_AW'(1);
    endfunction

    assign o_full           = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_head.valid     = (r_count != '0);
    assign o_head.token     = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop  ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count + QUEUE_CW'(i_push) - QUEUE_CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_token;
        end
    end

endmodule

>>> src/icr_back.sv
module icr_back
    import icr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_queue_head          i_head,
    output logic                 o_pop,
    input  logic [MIN_RUN_W-1:0] i_min_run,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [POS_W-1:0]     o_group_start,
    output logic [POS_W-1:0]     o_group_stop
);

    logic             r_in_run,    n_in_run;
    logic [POS_W-1:0] r_run_begin, n_run_begin;
    logic [POS_W-1:0] r_run_end,   n_run_end;
    logic [POS_W-1:0] r_pos,       n_pos;
    logic             r_out_valid;
    logic [POS_W-1:0] r_group_start;
    logic [POS_W-1:0] r_group_stop;

    logic             ident;
    logic             last;
    logic             close_now;
    logic [LEN_W-1:0] run_len;
    logic             emit;

    assign ident = i_head.token.identical;
    assign last  = i_head.token.last;

    // Advance only when the output register can take a result
    assign o_pop = i_head.valid && (!r_out_valid || i_out_ready);

    always_comb begin
        if (ident) begin
            n_run_begin = r_in_run ? r_run_begin : r_pos;
            n_run_end   = r_pos;
        end else begin
            n_run_begin = r_run_begin;
            n_run_end   = r_run_end;
        end
        close_now = (r_in_run && !ident) || (last && (r_in_run || ident));
        run_len   = {1'b0, n_run_end} - {1'b0, n_run_begin} + LEN_W'(1);
        emit      = o_pop && close_now && (run_len >= i_min_run);
        n_in_run  = ident && !last;
        if (last) begin
            n_pos = '0;
        end else if (r_pos < POS_LIMIT) begin
            n_pos = r_pos + POS_W'(1);
        end else begin
            n_pos = r_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_run    <= 1'b0;
            r_run_begin <= '0;
            r_run_end   <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_in_run    <= n_in_run;
                r_run_begin <= n_run_begin;
                r_run_end   <= n_run_end;
                r_pos       <= n_pos;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_group_start <= n_run_begin;
            r_group_stop  <= n_run_end;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_group_start = r_group_start;
    assign o_group_stop  = r_group_stop;

endmodule

>>> src/identical_column_run_finder_unit.sv
// Identical column run finder.
// Input channel (i_in_valid / o_in_ready): one beat is one alignment column,
//   32 row bytes over four 64-bit fields plus the last-column flag.
// Output channel (o_out_valid / i_out_ready): one beat is one reported run,
//   group_start and group_stop column indices.
// Config channel (i_cfg_valid / o_cfg_ready, always ready): index 0 sets
//   row_count, index 1 sets min_run; other indices are dropped. Write only
//   while the block is idle.
// Throughput: one column per cycle while the back is not held. The front
//   compares all rows of a column combinationally and pushes a classification
//   token into a two-entry queue; the back, when not held, pops one token per
//   cycle into the run tracker. A token is registered in the queue; the run it
//   closes is registered in the output register as that token is popped.
// Stall: while a result waits in the output register the back holds; the queue
//   fills in two beats and then o_in_ready drops until the result is taken.
// Reset (synchronous, active low): empties the queue and output register,
//   closes any open run, sets the column index to zero, row_count and min_run
//   to one. No clearing pass is needed.
module identical_column_run_finder_unit
    import icr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [FIELD_W-1:0]     i_rows_0_to_7,
    input  logic [FIELD_W-1:0]     i_rows_8_to_15,
    input  logic [FIELD_W-1:0]     i_rows_16_to_23,
    input  logic [FIELD_W-1:0]     i_rows_24_to_31,
    input  logic                   i_last_column,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [POS_W-1:0]       o_group_start,
    output logic [POS_W-1:0]       o_group_stop,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    logic [ROW_COUNT_W-1:0] r_row_count;
    logic [MIN_RUN_W-1:0]   r_min_run;

    t_token      front_token;
    logic        queue_full;
    logic        push;
    logic        pop;
    t_queue_head head;

    // Config registers: always ready, drop writes to unknown indices
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= ROW_COUNT_W'(1);
            r_min_run   <= MIN_RUN_W'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ROW_COUNT: r_row_count <= i_cfg_data[ROW_COUNT_W-1:0];
                CFG_MIN_RUN:   r_min_run   <= i_cfg_data[MIN_RUN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Front: classify the column in the cycle it arrives
    icr_front u_front (
        .i_rows_0_to_7   (i_rows_0_to_7),
        .i_rows_8_to_15  (i_rows_8_to_15),
        .i_rows_16_to_23 (i_rows_16_to_23),
        .i_rows_24_to_31 (i_rows_24_to_31),
        .i_last_column   (i_last_column),
        .i_row_count     (r_row_count),
        .o_token         (front_token)
    );

    // Accept a beat whenever the queue has room
    assign o_in_ready = !queue_full;
    assign push       = i_in_valid && o_in_ready;

    icr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_token (front_token),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_head  (head)
    );

    // Back: run tracker and output register
    icr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .o_pop         (pop),
        .i_min_run     (r_min_run),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_group_start (o_group_start),
        .o_group_stop  (o_group_stop)
    );

endmodule

>>> src/icr_checker.sv
module icr_checker
    import icr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             o_out_valid,
    input  logic             i_out_ready,
    input  logic [POS_W-1:0] o_group_start,
    input  logic [POS_W-1:0] o_group_stop
);

    // A reported run never ends before it starts
    a_stop_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_group_stop >= o_group_start))
        else $error("group_stop below group_start");

    // Reset empties the output register
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered straight after reset");

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its indices
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> ($stable(o_group_start) && $stable(o_group_stop)))
        else $error("result changed while stalled");

endmodule

bind identical_column_run_finder_unit icr_checker u_icr_checker (.*);

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import icr_pkg::*;

    // Column beats go in on one channel, reported runs come out on the other.
    // A local tracker of the run state predicts every report. Each reported
    // beat is checked against the oldest prediction.

    localparam int unsigned SETTLE_CYCLES   = 8;    // pop, tracker, output register, margin
    localparam int unsigned WATCHDOG_LIMIT  = 2000; // quiet cycles before giving up
    localparam int unsigned HOLD_OFF_CYCLES = 300;  // long receiver stall for the fill test

    // Spare register indexes: the block must drop writes to these
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE     = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_TOP = '1;

    typedef struct packed {
        logic                   last;
        logic [4*FIELD_W-1:0]   chars;  // row r in chars[8*r +: 8]
    } t_column;

    typedef struct packed {
        logic [POS_W-1:0] start;
        logic [POS_W-1:0] stop;
    } t_run;

    typedef enum int unsigned {
        COL_SAME,   // all compared rows equal, row 0 not a gap
        COL_DIFF,   // one compared row differs (row 0 gapped when only one row)
        COL_GAP,    // row 0 is the gap byte
        COL_NOISE   // fully random bytes
    } t_col_kind;

    typedef enum int unsigned {
        RX_ALWAYS,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } t_stall_mode;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_ready;
    logic [FIELD_W-1:0]     i_rows_0_to_7;
    logic [FIELD_W-1:0]     i_rows_8_to_15;
    logic [FIELD_W-1:0]     i_rows_16_to_23;
    logic [FIELD_W-1:0]     i_rows_24_to_31;
    logic                   i_last_column;
    logic                   o_out_valid;
    logic                   i_out_ready;
    logic [POS_W-1:0]       o_group_start;
    logic [POS_W-1:0]       o_group_stop;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    // Local copy of the block's registers and run state
    logic [ROW_COUNT_W-1:0] cfg_rows;
    logic [MIN_RUN_W-1:0]   cfg_min_run;
    logic                   run_open;
    logic [POS_W-1:0]       run_first;
    logic [POS_W-1:0]       run_last;
    logic [POS_W-1:0]       next_col;

    t_run        pending_runs[$];
    int unsigned mismatches    = 0;
    int unsigned columns_sent  = 0;
    int unsigned burst_left    = 0;
    bit          sender_steady = 1'b0;
    int unsigned hold_requests = 0;
    int unsigned quiet_cycles  = 0;

    identical_column_run_finder_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_rows_0_to_7   (i_rows_0_to_7),
        .i_rows_8_to_15  (i_rows_8_to_15),
        .i_rows_16_to_23 (i_rows_16_to_23),
        .i_rows_24_to_31 (i_rows_24_to_31),
        .i_last_column   (i_last_column),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_group_start   (o_group_start),
        .o_group_stop    (o_group_stop),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Run tracker
    // ------------------------------------------------------------------

    // Row count zero compares row 0 alone; anything above the array saturates
    function automatic int unsigned used_rows();
        if (cfg_rows == 0) return 1;
        if (cfg_rows > MAX_ROWS) return MAX_ROWS;
        return cfg_rows;
    endfunction

    function automatic logic column_matches(t_column col);
        int unsigned r;
        if (col.chars[7:0] == GAP_BYTE) return 1'b0;
        for (r = 1; r < used_rows(); r++) begin
            if (col.chars[8*r +: 8] != col.chars[7:0]) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Close the open run; queue a report when it is long enough
    task automatic close_open_run();
        logic [LEN_W-1:0] span;
        span = {1'b0, run_last} - {1'b0, run_first} + LEN_W'(1);
        run_open = 1'b0;
        if (span >= cfg_min_run) pending_runs.push_back('{start: run_first, stop: run_last});
    endtask

    task automatic track_column(input t_column col);
        logic [POS_W-1:0] here;
        here = next_col;
        if (column_matches(col)) begin
            if (!run_open) begin
                run_first = here;
                run_open  = 1'b1;
            end
            run_last = here;
        end else if (run_open) begin
            close_open_run();
        end
        // The final column closes whatever is still open and rewinds the index
        if (col.last) begin
            if (run_open) close_open_run();
            next_col = '0;
        end else if (here < POS_LIMIT) begin
            next_col = here + POS_W'(1);
        end
    endtask

    // ------------------------------------------------------------------
    // Column builders
    // ------------------------------------------------------------------

    function automatic t_column uniform_column(logic [7:0] ch, logic last);
        t_column c;
        c.chars = {32{ch}};
        c.last  = last;
        return c;
    endfunction

    function automatic t_column make_column(t_col_kind kind, logic last);
        t_column     c;
        logic [7:0]  ch;
        int unsigned n, r;
        n = used_rows();
        c.chars = {$urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom};
        c.last = last;
        case (kind)
            COL_SAME, COL_DIFF: begin
                do ch = 8'($urandom); while (ch == GAP_BYTE);
                // Rows beyond the compared ones: sometimes equal, sometimes junk
                if ($urandom_range(0, 1)) c.chars = {32{ch}};
                for (r = 0; r < n; r++) c.chars[8*r +: 8] = ch;
                if (kind == COL_DIFF) begin
                    if (n == 1) begin
                        c.chars[7:0] = GAP_BYTE;
                    end else begin
                        r = $urandom_range(1, n - 1);
                        c.chars[8*r +: 8] = ch ^ 8'($urandom_range(1, 255));
                    end
                end
            end
            COL_GAP: begin
                if ($urandom_range(0, 1)) c.chars = {32{GAP_BYTE}};
                c.chars[7:0] = GAP_BYTE;
            end
            default: begin
            end
        endcase
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------

    // Offer one column beat; idle first when the current burst is spent, unless the sender is steady
    task automatic send_column(input t_column col);
        int unsigned gap;
        gap = 0;
        if (!sender_steady && burst_left == 0) begin
            gap        = $urandom_range(1, 12);
            burst_left = $urandom_range(1, 40);
        end
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_rows_0_to_7   <= col.chars[0*FIELD_W +: FIELD_W];
        i_rows_8_to_15  <= col.chars[1*FIELD_W +: FIELD_W];
        i_rows_16_to_23 <= col.chars[2*FIELD_W +: FIELD_W];
        i_rows_24_to_31 <= col.chars[3*FIELD_W +: FIELD_W];
        i_last_column   <= col.last;
        if (burst_left != 0) burst_left--;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        track_column(col);
        columns_sent++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        if (index == CFG_ROW_COUNT) cfg_rows = data[ROW_COUNT_W-1:0];
        else if (index == CFG_MIN_RUN) cfg_min_run = data[MIN_RUN_W-1:0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Drop valid, wait for every report, then let columns with no report drain
    task automatic settle_block();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_runs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        burst_left = 0;
    endtask

    // Runs of matching columns broken by mismatches, gaps and noise
    task automatic send_alignment(input int unsigned length, input bit closed);
        t_col_kind   kind;
        int unsigned k, roll;
        kind = COL_SAME;
        for (k = 0; k < length; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) kind = COL_NOISE;
            else if (roll < ((kind == COL_SAME) ? 80 : 45)) kind = COL_SAME;
            else if (roll < 90) kind = COL_DIFF;
            else kind = COL_GAP;
            send_column(make_column(kind, closed && (k == length - 1)));
        end
    endtask

    task automatic pick_settings(input bit rare_reports);
        logic [ROW_COUNT_W-1:0] rows;
        logic [MIN_RUN_W-1:0]   limit;
        case ($urandom_range(0, 5))
            0:       rows = '0;
            1:       rows = ROW_COUNT_W'(1);
            2:       rows = ROW_COUNT_W'(MAX_ROWS);
            3:       rows = '1;
            4:       rows = ROW_COUNT_W'($urandom_range(2, 31));
            default: rows = ROW_COUNT_W'($urandom);
        endcase
        limit = rare_reports ? MIN_RUN_W'($urandom_range(1000, 131071))
                             : MIN_RUN_W'($urandom_range(0, 6));
        // Upper data bits are junk for the row count: the register keeps six
        if ($urandom_range(0, 1)) begin
            write_reg(CFG_MIN_RUN, limit);
            write_reg(CFG_ROW_COUNT, {11'($urandom), rows});
        end else begin
            write_reg(CFG_ROW_COUNT, {11'($urandom), rows});
            write_reg(CFG_MIN_RUN, limit);
        end
        if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_directed_columns();
        t_column col;
        // Reset settings: row 0 only, single-column runs reported
        send_column(uniform_column(8'h00, 1'b0));
        send_column(uniform_column(8'hFF, 1'b0));
        send_column(uniform_column(GAP_BYTE, 1'b0));        // gap closes run 0..1
        col = make_column(COL_NOISE, 1'b0);
        col.chars[7:0] = 8'h41;                             // other rows ignored
        send_column(col);
        col = make_column(COL_NOISE, 1'b1);
        col.chars[7:0] = GAP_BYTE;                          // last column, not part of run
        send_column(col);
        send_column(uniform_column(8'h5A, 1'b1));           // one-column alignment
        settle_block();

        // All rows compared, every run reported however short
        write_reg(CFG_ROW_COUNT, CFG_DATA_W'(MAX_ROWS));
        write_reg(CFG_MIN_RUN, '0);
        col = uniform_column(8'h41, 1'b0);
        col.chars[255:248] = 8'h42;                         // top row spoils it
        send_column(col);
        send_column(uniform_column(8'h43, 1'b0));
        col = uniform_column(8'h43, 1'b0);
        col.chars[255:248] = 8'h44;
        send_column(col);
        send_column(uniform_column(8'h45, 1'b1));
        settle_block();

        // Oversized row count saturates; longest minimum suppresses everything
        write_reg(CFG_ROW_COUNT, CFG_DATA_W'(6'h3F));
        write_reg(CFG_MIN_RUN, '1);
        repeat (3) send_column(uniform_column(8'h7E, 1'b0));
        col = uniform_column(8'h7E, 1'b1);
        col.chars[255:248] = 8'h7F;
        send_column(col);
        settle_block();

        // Row count zero behaves as one row
        write_reg(CFG_ROW_COUNT, '0);
        write_reg(CFG_MIN_RUN, CFG_DATA_W'(3));
        repeat (2) begin
            col = make_column(COL_NOISE, 1'b0);
            col.chars[7:0] = 8'h78;
            send_column(col);
        end
        send_column(uniform_column(GAP_BYTE, 1'b0));        // two-column run too short
        repeat (3) send_column(uniform_column(8'h80, 1'b0));
        send_column(uniform_column(8'h80, 1'b1));           // run 3..6 closed by last
        settle_block();

        // Writes to spare indexes must leave both registers alone
        write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
        write_reg(CFG_INDEX_TOP, CFG_DATA_W'($urandom));
        send_column(uniform_column(8'h71, 1'b1));
        settle_block();
    endtask

    // Receiver holds off while columns keep coming: queue fills, input stalls
    task automatic test_input_backpressure();
        int unsigned k;
        write_reg(CFG_ROW_COUNT, CFG_DATA_W'(8));
        write_reg(CFG_MIN_RUN, '0);
        hold_requests++;
        sender_steady = 1'b1;
        for (k = 0; k < 64; k++)
            send_column(make_column(k[0] ? COL_DIFF : COL_SAME, k == 63));
        sender_steady = 1'b0;
        settle_block();
    endtask

    task automatic test_random_alignments();
        int unsigned phase, target;
        for (phase = 0; phase < 6; phase++) begin
            pick_settings(phase == 3);
            target = columns_sent + 300;
            while (columns_sent < target)
                send_alignment(($urandom_range(0, 9) < 8) ? $urandom_range(1, 24)
                                                          : $urandom_range(25, 120),
                               $urandom_range(0, 9) != 0);
            settle_block();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------

    initial begin
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_rows_0_to_7   <= '0;
        i_rows_8_to_15  <= '0;
        i_rows_16_to_23 <= '0;
        i_rows_24_to_31 <= '0;
        i_last_column   <= 1'b0;
        i_cfg_valid     <= 1'b0;
        i_cfg_index     <= '0;
        i_cfg_data      <= '0;
        cfg_rows    = ROW_COUNT_W'(1);
        cfg_min_run = MIN_RUN_W'(1);
        run_open    = 1'b0;
        run_first   = '0;
        run_last    = '0;
        next_col    = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_columns();
        test_input_backpressure();
        test_random_alignments();

        if (mismatches == 0) $display("identical_column_run_finder_unit test passed");
        else $display("identical_column_run_finder_unit test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: stalls on its own pattern, plus the long hold-off on request
    // ------------------------------------------------------------------

    initial begin : out_ready_pattern
        t_stall_mode mode;
        int unsigned mode_left, hold_left, holds_served;
        mode         = RX_ALWAYS;
        mode_left    = 0;
        hold_left    = 0;
        holds_served = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (holds_served != hold_requests) begin
                holds_served++;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_stall_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(10, 120);
                end
                mode_left--;
                case (mode)
                    RX_ALWAYS:   i_out_ready <= 1'b1;
                    RX_COIN:     i_out_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE:   i_out_ready <= ($urandom_range(0, 3) == 0);
                    default:     i_out_ready <= (mode_left % 4 != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Report checker: each accepted beat against the oldest prediction
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin : report_check
        t_run want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            if (pending_runs.size() == 0) begin
                $error("unexpected run reported: group_start %0d, group_stop %0d",
                       o_group_start, o_group_stop);
                mismatches++;
            end else begin
                want = pending_runs.pop_front();
                if (o_group_start !== want.start) begin
                    $error("group_start: expected %0d, got %0d", want.start, o_group_start);
                    mismatches++;
                end
                if (o_group_stop !== want.stop) begin
                    $error("group_stop: expected %0d, got %0d", want.stop, o_group_stop);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: give up after too many cycles with no beat on any channel
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1
            || (i_in_valid === 1'b1 && o_in_ready === 1'b1)
            || (o_out_valid === 1'b1 && i_out_ready === 1'b1)
            || (i_cfg_valid === 1'b1 && o_cfg_ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("identical_column_run_finder_unit test failed");
            $finish;
        end
    end

endmodule

>>> identical_column_run_finder_unit.f
src/icr_pkg.sv
src/icr_front.sv
src/icr_queue.sv
src/icr_back.sv
src/identical_column_run_finder_unit.sv
src/icr_checker.sv
tb/tb.sv
